@@ rtl/polygon_centroid_defines.svh @@
// ----------------------------------------------------------------------------
// polygon_centroid_defines
// Assertion macros shared by the centroid block.
// ----------------------------------------------------------------------------
`ifndef POLYGON_CENTROID_DEFINES_SVH
`define POLYGON_CENTROID_DEFINES_SVH

// Check that a condition implies another in the same cycle, outside reset.
`define PC_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("polygon_centroid: implication check failed");

// Check that a condition implies another in the next cycle, outside reset.
`define PC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("polygon_centroid: next-cycle check failed");

`endif

@@ rtl/pcent_pkg.sv @@
// ----------------------------------------------------------------------------
// pcent_pkg
// Widths and status codes of the polygon centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcent_pkg;

    localparam int COORD_W = 16;   // port width of a coordinate
    localparam int CROSS_W = 33;   // one cross product x0*y1 - x1*y0
    localparam int SUMC_W  = 17;   // sum of two coordinates
    localparam int MUL_W   = 50;   // shared multiplier product
    localparam int AREA_W  = 44;   // cross product sum
    localparam int MOM_W   = 61;   // moment sums
    localparam int DEN_W   = 46;   // three times the area sum
    localparam int STAT_W  = 2;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_ZERO = 2'd1;
    localparam t_status ST_SAT  = 2'd2;
    localparam t_status ST_OVER = 2'd3;

endpackage

`default_nettype wire

@@ rtl/polygon_centroid.sv @@
// ----------------------------------------------------------------------------
// polygon_centroid
// Streaming shoelace centroid of a polygon given vertex by vertex.
// ----------------------------------------------------------------------------
// Vertices come in one word at a time as signed Q12.4 (low COORD_BITS bits
// used); the word with last_vertex set closes the polygon and yields one
// result word. Each edge runs through one shared 17x33 multiplier: two
// products for the cross term, one subtract, then the two moment products
// with the area, x and y accumulates folded in. The closing divide, skipped
// for status 1 and 3, runs a restoring divider one quotient bit per cycle
// over 61 bits, once for x and once for y. Status: 0 ok, 1 zero area
// (centroid 0), 2 saturated, 3 more than MAX_VERTICES vertices (centroid 0).
// The block takes no new vertex while it works, nor while a finished result
// waits for the result word before it to be taken.
`default_nettype none

`include "polygon_centroid_defines.svh"

module polygon_centroid #(
    parameter int COORD_BITS   = 16,
    parameter int MAX_VERTICES = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic signed [pcent_pkg::COORD_W-1:0] i_x_coord,
    input  wire logic signed [pcent_pkg::COORD_W-1:0] i_y_coord,
    input  wire logic                             i_last_vertex,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic signed [pcent_pkg::COORD_W-1:0]  o_centroid_x,
    output logic signed [pcent_pkg::COORD_W-1:0]  o_centroid_y,
    output pcent_pkg::t_status                    o_status
);

    import pcent_pkg::*;

    localparam int CNT_W  = $clog2(MAX_VERTICES + 2);
    localparam int SH     = COORD_W - COORD_BITS;
    localparam int DCNT_W = $clog2(MOM_W + 1);

    localparam logic [MOM_W-1:0] SAT_HI = MOM_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic [MOM_W-1:0] SAT_LO = MOM_W'(64'd1 << (COORD_BITS - 1));
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_VERTICES + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TAKE = 4'd1;
    localparam logic [3:0] S_P1   = 4'd2;
    localparam logic [3:0] S_P2   = 4'd3;
    localparam logic [3:0] S_SUB  = 4'd4;
    localparam logic [3:0] S_MX   = 4'd5;
    localparam logic [3:0] S_MY   = 4'd6;
    localparam logic [3:0] S_ACC  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_DSET = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]                 r_state;
    logic signed [COORD_W-1:0]  r_cur_x, r_cur_y, r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic                       r_last;
    logic                       r_close;
    logic [CNT_W-1:0]           r_count;
    logic signed [CROSS_W-1:0]  r_a;
    logic signed [MUL_W-1:0]    r_prod;
    logic signed [AREA_W-1:0]   r_area;
    logic signed [MOM_W-1:0]    r_mx, r_my;
    logic signed [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]           r_dmag;
    logic [DEN_W:0]             r_rem;
    logic [MOM_W-1:0]           r_quo;
    logic                       r_neg;
    logic                       r_sel;
    logic [DCNT_W-1:0]          r_dcnt;
    logic signed [COORD_W-1:0]  r_res_x;
    logic                       r_sat_x;
    logic                       r_out_valid;
    logic signed [COORD_W-1:0]  r_out_x, r_out_y;
    t_status                    r_out_status;
    t_status                    r_fin_status;

    // sign-extend the low COORD_BITS bits of the inputs
    logic signed [COORD_W-1:0] in_x_sh, in_y_sh, in_x, in_y;
    assign in_x_sh = i_x_coord <<< SH;
    assign in_y_sh = i_y_coord <<< SH;
    assign in_x    = in_x_sh >>> SH;
    assign in_y    = in_y_sh >>> SH;

    // edge endpoints: open edge prev->cur, closing edge cur->first
    logic signed [COORD_W-1:0] e_x0, e_y0, e_x1, e_y1;
    assign e_x0 = r_close ? r_cur_x   : r_prev_x;
    assign e_y0 = r_close ? r_cur_y   : r_prev_y;
    assign e_x1 = r_close ? r_first_x : r_cur_x;
    assign e_y1 = r_close ? r_first_y : r_cur_y;

    // shared multiplier operand select
    logic signed [SUMC_W-1:0]  mul_a;
    logic signed [CROSS_W-1:0] mul_b;
    logic signed [MUL_W-1:0]   mul_p;
    always_comb begin
        case (r_state)
            S_P1: begin
                mul_a = SUMC_W'(e_x0);
                mul_b = CROSS_W'(e_y1);
            end
            S_P2: begin
                mul_a = SUMC_W'(e_x1);
                mul_b = CROSS_W'(e_y0);
            end
            S_MX: begin
                mul_a = SUMC_W'(e_x0) + SUMC_W'(e_x1);
                mul_b = r_a;
            end
            default: begin
                mul_a = SUMC_W'(e_y0) + SUMC_W'(e_y1);
                mul_b = r_a;
            end
        endcase
        mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
    end

    // divider step: shift in one dividend bit, subtract when it fits
    logic [DEN_W:0] rem_sh;
    logic           rem_ge;
    assign rem_sh = {r_rem[DEN_W-1:0], r_quo[MOM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dmag};

    // saturate the finished quotient magnitude
    logic signed [COORD_W-1:0] q_val;
    logic                      q_sat;
    always_comb begin
        if (!r_neg) begin
            q_sat = r_quo > SAT_HI;
            q_val = q_sat ? COORD_W'(SAT_HI) : COORD_W'(r_quo);
        end else begin
            q_sat = r_quo > SAT_LO;
            q_val = q_sat ? -COORD_W'(SAT_LO) : -COORD_W'(r_quo);
        end
    end

    logic signed [MOM_W-1:0] mom_sel;
    assign mom_sel = r_sel ? r_my : r_mx;

    logic out_free;
    assign out_free = !r_out_valid || i_ready;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_area      <= '0;
            r_mx        <= '0;
            r_my        <= '0;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_close     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken word unless a new one is loaded this cycle
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cur_x <= in_x;
                        r_cur_y <= in_y;
                        r_last  <= i_last_vertex;
                        r_close <= 1'b0;
                        r_state <= S_TAKE;
                    end
                end
                S_TAKE: begin
                    if (r_count >= CNT_MAX) begin
                        r_count <= CNT_OVER;
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end else begin
                        r_count <= r_count + 1'b1;
                        if (r_count == '0) begin
                            r_first_x <= r_cur_x;
                            r_first_y <= r_cur_y;
                            r_prev_x  <= r_cur_x;
                            r_prev_y  <= r_cur_y;
                            // closing edge of a single vertex adds nothing
                            r_state   <= r_last ? S_FIN : S_IDLE;
                        end else begin
                            r_state <= S_P1;
                        end
                    end
                end
                S_P1: begin
                    r_prod  <= mul_p;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_a     <= r_prod[CROSS_W-1:0];
                    r_prod  <= mul_p;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_a     <= r_a - r_prod[CROSS_W-1:0];
                    r_state <= S_MX;
                end
                S_MX: begin
                    r_area  <= r_area + AREA_W'(r_a);
                    r_prod  <= mul_p;
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_mx    <= r_mx + MOM_W'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_my <= r_my + MOM_W'(r_prod);
                    if (r_close) begin
                        r_state <= S_FIN;
                    end else begin
                        r_prev_x <= r_cur_x;
                        r_prev_y <= r_cur_y;
                        if (r_last) begin
                            r_close <= 1'b1;
                            r_state <= S_P1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FIN: begin
                    r_den <= DEN_W'(r_area) + (DEN_W'(r_area) <<< 1);
                    r_sel <= 1'b0;
                    if (r_count > CNT_MAX) begin
                        r_fin_status <= ST_OVER;
                        r_res_x      <= '0;
                        r_state      <= S_DONE;
                    end else if (r_area == '0) begin
                        r_fin_status <= ST_ZERO;
                        r_res_x      <= '0;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    r_dmag  <= r_den[DEN_W-1] ? DEN_W'(-r_den) : DEN_W'(r_den);
                    r_quo   <= mom_sel[MOM_W-1] ? MOM_W'(-mom_sel) : MOM_W'(mom_sel);
                    r_neg   <= mom_sel[MOM_W-1] ^ r_den[DEN_W-1];
                    r_rem   <= '0;
                    r_dcnt  <= DCNT_W'(MOM_W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_dcnt != '0) begin
                        r_rem  <= rem_ge ? rem_sh - {1'b0, r_dmag} : rem_sh;
                        r_quo  <= {r_quo[MOM_W-2:0], rem_ge};
                        r_dcnt <= r_dcnt - 1'b1;
                    end else if (!r_sel) begin
                        r_res_x <= q_val;
                        r_sat_x <= q_sat;
                        r_sel   <= 1'b1;
                        r_state <= S_DSET;
                    end else begin
                        r_fin_status <= (q_sat || r_sat_x) ? ST_SAT : ST_OK;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_x      <= r_res_x;
                        r_out_y      <= (r_fin_status == ST_OK || r_fin_status == ST_SAT)
                                        ? q_val : '0;
                        r_out_status <= r_fin_status;
                        // start a fresh polygon
                        r_count      <= '0;
                        r_area       <= '0;
                        r_mx         <= '0;
                        r_my         <= '0;
                        r_first_x    <= '0;
                        r_first_y    <= '0;
                        r_prev_x     <= '0;
                        r_prev_y     <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_centroid_x = r_out_x;
    assign o_centroid_y = r_out_y;
    assign o_status     = r_out_status;

    // checks on the block's own logic
    `PC_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_OVER)
    `PC_ASSERT_IMPL(a_zero_out, i_clk, i_rst_n,
        o_valid && (o_status == ST_ZERO || o_status == ST_OVER),
        o_centroid_x == '0 && o_centroid_y == '0)
    `PC_ASSERT_NEXT(a_take_step, i_clk, i_rst_n, i_valid && o_ready, r_state == S_TAKE)
    `PC_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, r_state == S_DSET, r_area != '0)

endmodule

`default_nettype wire

@@ bench/tb_polygon_centroid.sv @@
// ----------------------------------------------------------------------------
// tb_polygon_centroid
// Self-checking bench for the streaming shoelace centroid block.
// ----------------------------------------------------------------------------
// Polygons are sent vertex by vertex under random idling on both sides. A
// predictor keeps its own shoelace sums and queues the centroid word expected
// for every closing vertex; each output word is checked against the oldest.
// ----------------------------------------------------------------------------
`default_nettype none

class centroid_scoreboard;
    typedef struct {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        pcent_pkg::t_status st;
    } t_centroid;

    t_centroid  pending[$];
    int         n_fail;
    int         n_words;
    int         n_polys;
    int         n_status[4];
    longint     fst_x, fst_y, prv_x, prv_y;
    longint     area, mom_x, mom_y;
    int         n_vert;
    int         max_vert;

    function new(int mv);
        max_vert = mv;
        clear();
    endfunction

    function void clear();
        fst_x = 0; fst_y = 0; prv_x = 0; prv_y = 0;
        area = 0; mom_x = 0; mom_y = 0; n_vert = 0;
    endfunction

    function void add_edge(longint x0, longint y0, longint x1, longint y1);
        longint a;
        a = x0 * y1 - x1 * y0;
        area += a;
        mom_x += (x0 + x1) * a;
        mom_y += (y0 + y1) * a;
    endfunction

    function longint clamp(longint q, ref bit sat);
        if (q > 32767) begin sat = 1; return 32767; end
        if (q < -32768) begin sat = 1; return -32768; end
        return q;
    endfunction

    // Note an accepted vertex word and queue the centroid when it closes.
    function void note_vertex(logic signed [15:0] x, logic signed [15:0] y, logic lst);
        t_centroid e;
        longint den;
        bit sat;
        if (n_vert >= max_vert) begin
            n_vert = max_vert + 1;
        end else begin
            if (n_vert == 0) begin
                fst_x = x; fst_y = y;
            end else begin
                add_edge(prv_x, prv_y, x, y);
            end
            prv_x = x; prv_y = y;
            n_vert++;
            if (lst) add_edge(x, y, fst_x, fst_y);
        end
        if (!lst) return;
        e.cx = 0; e.cy = 0; sat = 0;
        if (n_vert > max_vert) begin
            e.st = pcent_pkg::ST_OVER;
        end else if (area == 0) begin
            e.st = pcent_pkg::ST_ZERO;
        end else begin
            den = 3 * area;
            e.cx = 16'(clamp(mom_x / den, sat));
            e.cy = 16'(clamp(mom_y / den, sat));
            e.st = sat ? pcent_pkg::ST_SAT : pcent_pkg::ST_OK;
        end
        pending.push_back(e);
        n_polys++;
        clear();
    endfunction

    // Check one result word against the oldest expected centroid.
    function void check_centroid(logic signed [15:0] cx, logic signed [15:0] cy,
                                 pcent_pkg::t_status st);
        t_centroid e;
        n_words++;
        if (pending.size() == 0) begin
            $error("unexpected result word cx=%0d cy=%0d status=%0d", cx, cy, st);
            n_fail++;
            return;
        end
        e = pending.pop_front();
        n_status[e.st]++;
        if (cx !== e.cx) begin
            $error("centroid_x: expected %0d, got %0d", e.cx, cx); n_fail++;
        end
        if (cy !== e.cy) begin
            $error("centroid_y: expected %0d, got %0d", e.cy, cy); n_fail++;
        end
        if (st !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, st); n_fail++;
        end
    endfunction
endclass

module tb_polygon_centroid;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXV      = 1024;
    localparam int LIMIT_CYC = 4000000;

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   i_valid = 0;
    logic                   o_ready;
    logic signed [15:0]     i_x_coord = 0;
    logic signed [15:0]     i_y_coord = 0;
    logic                   i_last_vertex = 0;
    logic                   o_valid;
    logic                   i_ready = 0;
    logic signed [15:0]     o_centroid_x;
    logic signed [15:0]     o_centroid_y;
    pcent_pkg::t_status     o_status;

    int  idle_pct = 0;
    int  stall_pct = 0;
    int  hold_off = 0;
    longint cycles = 0;
    int  n_sent = 0;

    centroid_scoreboard sb = new(MAXV);

    polygon_centroid #(.COORD_BITS(16), .MAX_VERTICES(MAXV)) dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Count cycles and stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC) begin
            $display("tb_polygon_centroid failed");
            $finish;
        end
    end

    // Check accepted result words.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_centroid(o_centroid_x, o_centroid_y, o_status);
    end

    // Drive output ready: long hold-off when asked, else random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one vertex word and hold it until accepted.
    task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, logic lst);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_x_coord <= x;
        i_y_coord <= y;
        i_last_vertex <= lst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_vertex(x, y, lst);
        n_sent++;
    endtask

    task automatic pause_line();
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rnd_coord(int mode);
        case (mode)
            0: return 16'($urandom());
            1: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
            default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    // Send one random polygon of n vertices.
    task automatic send_polygon(int n, int mode);
        for (int k = 0; k < n; k++)
            send_vertex(rnd_coord(mode), rnd_coord(mode), k == n - 1);
    endtask

    // Send a random regular-ish convex polygon around a center.
    task automatic send_convex(int n);
        int cx, cy, r;
        real ang;
        cx = $urandom_range(0, 40000) - 20000;
        cy = $urandom_range(0, 40000) - 20000;
        r  = $urandom_range(1, 12000);
        for (int k = 0; k < n; k++) begin
            ang = 6.2831853 * k / n;
            send_vertex(16'(cx + $rtoi(r * $cos(ang))), 16'(cy + $rtoi(r * $sin(ang))),
                        k == n - 1);
        end
    endtask

    task automatic drain();
        pause_line();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic random_phase(int polys);
        int n;
        for (int p = 0; p < polys; p++) begin
            n = $urandom_range(0, 9) < 8 ? $urandom_range(3, 8) : $urandom_range(1, 20);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_convex(n);
                5, 6: send_polygon(n, 0);
                7, 8: send_polygon(n, 1);
                default: send_polygon(n, 2);
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: single vertex, square, extremes, degenerate and near-corner triangles.
        send_vertex(16'sh0123, -16'sh0045, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0); send_vertex(16'sd160, 16'sd0, 1'b0);
        send_vertex(16'sd160, 16'sd160, 1'b0); send_vertex(16'sd0, 16'sd160, 1'b1);
        send_vertex(16'sh8000, 16'sh8000, 1'b0); send_vertex(16'sh7fff, 16'sh8000, 1'b0);
        send_vertex(16'sh7fff, 16'sh7fff, 1'b0); send_vertex(16'sh8000, 16'sh7fff, 1'b1);
        send_vertex(16'sd1, 16'sd1, 1'b0); send_vertex(16'sd2, 16'sd2, 1'b0);
        send_vertex(16'sd3, 16'sd3, 1'b1);
        send_vertex(16'sh7fff, 16'sh7fff, 1'b0); send_vertex(16'sh7ffe, 16'sh7fff, 1'b0);
        send_vertex(16'sh7fff, 16'sh7ffe, 1'b1);
        send_vertex(-16'sh7fff, -16'sh7fff, 1'b0); send_vertex(-16'sh7ffe, -16'sh7fff, 1'b0);
        send_vertex(-16'sh7fff, -16'sh7ffe, 1'b1);
        send_vertex(16'sh5555, 16'shaaaa, 1'b0); send_vertex(16'shaaaa, 16'sh5555, 1'b0);
        send_vertex(16'sh1234, 16'sh4321, 1'b1);
        drain();

        // Too many vertices: run past the limit.
        idle_pct = 0; stall_pct = 0;
        send_polygon(MAXV + 3, 0);
        drain();

        // Long receiver hold-off while vertices keep coming.
        hold_off <= 3000;
        random_phase(10);
        drain();

        idle_pct = 0;  stall_pct = 0;  random_phase(12);
        idle_pct = 78; stall_pct = 0;  random_phase(12);
        drain();
        idle_pct = 0;  stall_pct = 78; random_phase(12);
        idle_pct = 27; stall_pct = 27; random_phase(12);
        drain();
        idle_pct = 0;  stall_pct = 0;  random_phase(6);
        drain();

        $display("covered %0d vertex words, %0d polygons", n_sent, sb.n_polys);
        $display("status counts ok=%0d zero=%0d sat=%0d over=%0d",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3]);
        if (sb.n_fail == 0 && sb.pending.size() == 0)
            $display("tb_polygon_centroid passed");
        else
            $display("tb_polygon_centroid failed");
        $finish;
    end
endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/pcent_pkg.sv
rtl/polygon_centroid.sv
bench/tb_polygon_centroid.sv
